[design/pointer_value_murmur_hash_macros.svh]
// Assertion macros for the pointer value hash block
`ifndef POINTER_VALUE_MURMUR_HASH_MACROS_SVH
`define POINTER_VALUE_MURMUR_HASH_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PVMH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pvmh assertion failed");
`define PVMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pvmh assertion failed");
`else
`define PVMH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PVMH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/pvmh_pkg.sv]
// Types, constants and helpers shared by the pointer value hash modules
package pvmh_pkg;

    localparam int KEY_W   = 64;
    localparam int LEN_W   = 7;
    localparam int SEED_W  = 32;
    localparam int HASH_W  = 64;
    localparam int ROUND_W = 5;
    localparam int QUAD_W  = LEN_W - 2;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    localparam logic [63:0] MIX_C1    = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2    = 64'h4cf5ad432745937f;
    localparam logic [63:0] LANE1_ADD = 64'h0000000052dce729;
    localparam logic [63:0] LANE2_ADD = 64'h0000000038495ab5;
    localparam logic [63:0] FIN_M1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_M2    = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_OPA_BYTE1,
        DP_OPA_BYTE2,
        DP_OPA_ROT31,
        DP_OPA_ROT33,
        DP_MUL,
        DP_L1_MIX,
        DP_L1_SCALE,
        DP_L2_MIX,
        DP_L2_SCALE,
        DP_LEN_XOR,
        DP_ADD12,
        DP_ADD21,
        DP_OPA_FMIX1,
        DP_OPA_FMIX2,
        DP_OPA_FMIXACC,
        DP_L1_FIN,
        DP_L2_FIN,
        DP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        KC_C1,
        KC_C2,
        KC_M1,
        KC_M2
    } kc_sel_t;

    typedef enum logic [1:0] {
        MPH_LOW,
        MPH_CROSS_HI,
        MPH_CROSS_LO
    } mul_phase_t;

    typedef struct packed {
        dp_op_t               op;
        kc_sel_t              kc;
        mul_phase_t           mphase;
        logic [ROUND_W-1:0]   round;
    } pvmh_cmd_t;

    typedef struct packed {
        logic [QUAD_W-1:0] quads;
    } pvmh_status_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] amt);
        return (v << amt) | (v >> (7'd64 - {1'b0, amt}));
    endfunction

    function automatic logic [63:0] mul_const(input kc_sel_t kc);
        logic [63:0] k;
        case (kc)
            KC_C1:   k = MIX_C1;
            KC_C2:   k = MIX_C2;
            KC_M1:   k = FIN_M1;
            KC_M2:   k = FIN_M2;
            default: k = MIX_C1;
        endcase
        return k;
    endfunction

endpackage

[design/pointer_value_murmur_hash.sv]
// The shared 32x32 multiplier runs three partial products per 64-bit multiply, four multiplies
// per round and four in finalization; the number of rounds is min(length/4, MAX_ROUNDS).
// A new word is accepted only while the sequencer is idle, after the previous result has been
// written to the output register. A finished result waits in the output register; the sequencer
// stalls only when the next result is ready before the previous one is taken.
// Reset (aresetn low, synchronous): sequencer idles, output invalid, seed cleared to zero.
`include "pointer_value_murmur_hash_macros.svh"

module pointer_value_murmur_hash
    import pvmh_pkg::*;
#(
    parameter int MAX_ROUNDS = 31
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [SEED_W-1:0]    cfg_wdata,     // hash_seed
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // [63:0] key_value, [70:64] length_bytes, [71] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // [63:0] hash_value
);

    pvmh_cmd_t    cmd;
    pvmh_status_t status;

    pvmh_ctrl #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pvmh_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .hash_out  (m_tdata)
    );

    `PVMH_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `PVMH_ASSERT_IMPL(a_load_on_accept, aclk, aresetn, cmd.op == DP_LOAD, s_tvalid && s_tready)
    `PVMH_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_tvalid && !m_tready, cmd.op != DP_OUT)
    `PVMH_ASSERT_NEXT(a_out_sets_valid, aclk, aresetn, cmd.op == DP_OUT, m_tvalid)

endmodule

[design/pvmh_datapath.sv]
// Hash datapath: lanes, shared 32x32 multiplier with accumulator, seed and result registers
module pvmh_datapath
    import pvmh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [SEED_W-1:0]    cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  pvmh_cmd_t            cmd,
    output pvmh_status_t         status,
    output logic [HASH_W-1:0]    hash_out
);

    logic [SEED_W-1:0] seed_reg;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [63:0]       lane1_reg, lane1_next;
    logic [63:0]       lane2_reg, lane2_next;
    logic [63:0]       opa_reg, opa_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       hash_reg, hash_next;

    logic [7:0]  byte_val;
    logic [63:0] kval;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] mixed;

    assign byte_val = 8'(key_reg >> {cmd.round, 1'b0});
    assign kval     = mul_const(cmd.kc);
    assign mul_a    = (cmd.mphase == MPH_CROSS_LO) ? opa_reg[63:32] : opa_reg[31:0];
    assign mul_b    = (cmd.mphase == MPH_CROSS_HI) ? kval[63:32] : kval[31:0];
    assign prod     = mul_a * mul_b;
    assign mixed    = acc_reg ^ (acc_reg >> 33);

    always_comb begin
        key_next   = key_reg;
        len_next   = len_reg;
        lane1_next = lane1_reg;
        lane2_next = lane2_reg;
        opa_next   = opa_reg;
        acc_next   = acc_reg;
        hash_next  = hash_reg;
        case (cmd.op)
            DP_LOAD: begin
                key_next   = s_tdata[KEY_W-1:0];
                len_next   = s_tdata[KEY_W +: LEN_W];
                lane1_next = {32'd0, seed_reg};
                lane2_next = {32'd0, seed_reg};
            end
            DP_OPA_BYTE1:   opa_next = {56'd0, byte_val};
            DP_OPA_BYTE2:   opa_next = {43'd0, byte_val, 13'd0};
            DP_OPA_ROT31:   opa_next = rotl64(acc_reg, 6'd31);
            DP_OPA_ROT33:   opa_next = rotl64(acc_reg, 6'd33);
            DP_MUL: begin
                if (cmd.mphase == MPH_LOW) begin
                    acc_next = prod;
                end else begin
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                end
            end
            DP_L1_MIX:      lane1_next = rotl64(lane1_reg ^ acc_reg, 6'd27) + lane2_reg;
            DP_L1_SCALE:    lane1_next = {lane1_reg[61:0], 2'b00} + lane1_reg + LANE1_ADD;
            DP_L2_MIX:      lane2_next = rotl64(lane2_reg ^ acc_reg, 6'd31) + lane1_reg;
            DP_L2_SCALE:    lane2_next = {lane2_reg[61:0], 2'b00} + lane2_reg + LANE2_ADD;
            DP_LEN_XOR: begin
                lane1_next = lane1_reg ^ {57'd0, len_reg};
                lane2_next = lane2_reg ^ {57'd0, len_reg};
            end
            DP_ADD12:       lane1_next = lane1_reg + lane2_reg;
            DP_ADD21:       lane2_next = lane2_reg + lane1_reg;
            DP_OPA_FMIX1:   opa_next = lane1_reg ^ (lane1_reg >> 33);
            DP_OPA_FMIX2:   opa_next = lane2_reg ^ (lane2_reg >> 33);
            DP_OPA_FMIXACC: opa_next = mixed;
            DP_L1_FIN:      lane1_next = mixed;
            DP_L2_FIN:      lane2_next = mixed;
            DP_OUT:         hash_next = lane1_reg + lane2_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_wen) begin
            seed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        len_reg   <= len_next;
        lane1_reg <= lane1_next;
        lane2_reg <= lane2_next;
        opa_reg   <= opa_next;
        acc_reg   <= acc_next;
        hash_reg  <= hash_next;
    end

    assign status.quads = len_reg[LEN_W-1:2];
    assign hash_out     = hash_reg;

endmodule

[design/pvmh_ctrl.sv]
// Hash sequencer: round counter, multiply phase stepping and output handshake
module pvmh_ctrl
    import pvmh_pkg::*;
#(
    parameter int MAX_ROUNDS = 31
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  pvmh_status_t status,
    output pvmh_cmd_t    cmd
);

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_B1, ST_R1, ST_L1A, ST_L1B, ST_B2, ST_R2, ST_L2A, ST_L2B,
        ST_LENX, ST_ADD12, ST_ADD21, ST_F1A, ST_F1B, ST_F1C, ST_F2A, ST_F2B, ST_F2C,
        ST_OUT, ST_MUL
    } state_t;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    kc_sel_t          kc_reg, kc_next;
    mul_phase_t       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0] rounds_lim;

    assign rounds_lim = (32'(status.quads) > MAX_ROUNDS) ? CNT_W'(MAX_ROUNDS)
                                                          : CNT_W'(status.quads);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        kc_next       = kc_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd.op        = DP_NOP;
        cmd.kc        = kc_reg;
        cmd.mphase    = phase_reg;
        cmd.round     = ROUND_W'(cnt_reg);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cnt_next   = '0;
                state_next = (rounds_lim == '0) ? ST_LENX : ST_B1;
            end
            ST_B1: begin
                cmd.op     = DP_OPA_BYTE1;
                kc_next    = KC_C1;
                ret_next   = ST_R1;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_R1: begin
                cmd.op     = DP_OPA_ROT31;
                kc_next    = KC_C2;
                ret_next   = ST_L1A;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_L1A: begin
                cmd.op     = DP_L1_MIX;
                state_next = ST_L1B;
            end
            ST_L1B: begin
                cmd.op     = DP_L1_SCALE;
                state_next = ST_B2;
            end
            ST_B2: begin
                cmd.op     = DP_OPA_BYTE2;
                kc_next    = KC_C2;
                ret_next   = ST_R2;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_R2: begin
                cmd.op     = DP_OPA_ROT33;
                kc_next    = KC_C1;
                ret_next   = ST_L2A;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_L2A: begin
                cmd.op     = DP_L2_MIX;
                state_next = ST_L2B;
            end
            ST_L2B: begin
                cmd.op = DP_L2_SCALE;
                if (cnt_reg == rounds_lim - CNT_W'(1)) begin
                    state_next = ST_LENX;
                end else begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_B1;
                end
            end
            ST_LENX: begin
                cmd.op     = DP_LEN_XOR;
                state_next = ST_ADD12;
            end
            ST_ADD12: begin
                cmd.op     = DP_ADD12;
                state_next = ST_ADD21;
            end
            ST_ADD21: begin
                cmd.op     = DP_ADD21;
                state_next = ST_F1A;
            end
            ST_F1A: begin
                cmd.op     = DP_OPA_FMIX1;
                kc_next    = KC_M1;
                ret_next   = ST_F1B;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_F1B: begin
                cmd.op     = DP_OPA_FMIXACC;
                kc_next    = KC_M2;
                ret_next   = ST_F1C;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_F1C: begin
                cmd.op     = DP_L1_FIN;
                state_next = ST_F2A;
            end
            ST_F2A: begin
                cmd.op     = DP_OPA_FMIX2;
                kc_next    = KC_M1;
                ret_next   = ST_F2B;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_F2B: begin
                cmd.op     = DP_OPA_FMIXACC;
                kc_next    = KC_M2;
                ret_next   = ST_F2C;
                phase_next = MPH_LOW;
                state_next = ST_MUL;
            end
            ST_F2C: begin
                cmd.op     = DP_L2_FIN;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = DP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.op = DP_MUL;
                case (phase_reg)
                    MPH_LOW:      phase_next = MPH_CROSS_HI;
                    MPH_CROSS_HI: phase_next = MPH_CROSS_LO;
                    default: begin
                        phase_next = MPH_LOW;
                        state_next = ret_reg;
                    end
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            kc_reg       <= KC_C1;
            phase_reg    <= MPH_LOW;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            kc_reg       <= kc_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
